FILE: src/fsct_pkg.sv
`default_nettype none
package fsct_pkg;

	localparam int FIELD_W  = 16;
	localparam int RED_BITS = 14;
	localparam int RED_W    = RED_BITS + 1;
	localparam int DOT_W    = 2 * RED_BITS + 2;
	localparam int RAD_W    = 2 * DOT_W;
	localparam int ROOT_W   = DOT_W;
	localparam int QUO_W    = 8;
	localparam int NUM_W    = DOT_W + QUO_W;
	localparam int SQ_STEPS = ROOT_W;

	typedef enum logic [3:0] {
		REG_EYE_X    = 4'd0,
		REG_EYE_Y    = 4'd1,
		REG_EYE_Z    = 4'd2,
		REG_LIGHT_X  = 4'd3,
		REG_LIGHT_Y  = 4'd4,
		REG_LIGHT_Z  = 4'd5,
		REG_AMBIENT  = 4'd6,
		REG_DIFFUSE  = 4'd7
	} cfg_reg_e;

	typedef struct packed {
		logic signed [FIELD_W-1:0] vert0_x;
		logic signed [FIELD_W-1:0] vert0_y;
		logic signed [FIELD_W-1:0] vert0_z;
		logic signed [FIELD_W-1:0] vert1_x;
		logic signed [FIELD_W-1:0] vert1_y;
		logic signed [FIELD_W-1:0] vert1_z;
		logic signed [FIELD_W-1:0] vert2_x;
		logic signed [FIELD_W-1:0] vert2_y;
		logic signed [FIELD_W-1:0] vert2_z;
	} in_item_t;

	typedef struct packed {
		logic       visible;
		logic [7:0] intensity;
		logic [6:0] half_intensity;
	} out_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] eye_x;
		logic signed [FIELD_W-1:0] eye_y;
		logic signed [FIELD_W-1:0] eye_z;
		logic signed [FIELD_W-1:0] light_x;
		logic signed [FIELD_W-1:0] light_y;
		logic signed [FIELD_W-1:0] light_z;
		logic [7:0]                ambient_term;
		logic [7:0]                diffuse_gain;
	} cfg_t;

	typedef struct packed {
		logic             visible;
		logic             pos;
		logic [DOT_W-1:0] dmag;
		logic [RAD_W-1:0] rad;
	} rad_item_t;

	typedef struct packed {
		logic              visible;
		logic              pos;
		logic [DOT_W-1:0]  dmag;
		logic [ROOT_W-1:0] root;
	} root_item_t;

endpackage
`default_nettype wire

FILE: src/fsct_cfg.sv
`default_nettype none
module fsct_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [3:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output fsct_pkg::cfg_t regs
);
	import fsct_pkg::*;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.eye_x        <= 16'sd0;
			regs_q.eye_y        <= 16'sd0;
			regs_q.eye_z        <= 16'sd12288;
			regs_q.light_x      <= 16'sd0;
			regs_q.light_y      <= 16'sd0;
			regs_q.light_z      <= 16'sd12288;
			regs_q.ambient_term <= 8'd50;
			regs_q.diffuse_gain <= 8'd160;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EYE_X:   regs_q.eye_x        <= $signed(cfg_data);
				REG_EYE_Y:   regs_q.eye_y        <= $signed(cfg_data);
				REG_EYE_Z:   regs_q.eye_z        <= $signed(cfg_data);
				REG_LIGHT_X: regs_q.light_x      <= $signed(cfg_data);
				REG_LIGHT_Y: regs_q.light_y      <= $signed(cfg_data);
				REG_LIGHT_Z: regs_q.light_z      <= $signed(cfg_data);
				REG_AMBIENT: regs_q.ambient_term <= cfg_data[7:0];
				REG_DIFFUSE: regs_q.diffuse_gain <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/fsct_geom.sv
`default_nettype none
module fsct_geom #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                in_vld,
	input  fsct_pkg::in_item_t  in_item,
	input  fsct_pkg::cfg_t      cfg,
	output logic                out_vld,
	output fsct_pkg::rad_item_t out_item
);
	import fsct_pkg::*;

	localparam int VW  = (COORD_WIDTH > FIELD_W) ? FIELD_W + 1 : COORD_WIDTH;
	localparam int EW  = VW + 1;
	localparam int SW  = VW + 2;
	localparam int PW  = 2 * EW;
	localparam int NW  = PW + 1;
	localparam int TW  = ((SW > FIELD_W + 2) ? SW : FIELD_W + 2) + 1;
	localparam int CPW = NW + TW;
	localparam int CSW = CPW + 2;
	localparam int SHN = $clog2(NW + 1);
	localparam int SHL = $clog2(TW + 1);
	localparam int SQW = 2 * RED_BITS;

	logic [FIELD_W-1:0] fld [9];
	logic signed [VW-1:0] v [9];

	assign fld[0] = in_item.vert0_x;
	assign fld[1] = in_item.vert0_y;
	assign fld[2] = in_item.vert0_z;
	assign fld[3] = in_item.vert1_x;
	assign fld[4] = in_item.vert1_y;
	assign fld[5] = in_item.vert1_z;
	assign fld[6] = in_item.vert2_x;
	assign fld[7] = in_item.vert2_y;
	assign fld[8] = in_item.vert2_z;

	// wide coordinates: the field has no sign bit
	for (genvar g = 0; g < 9; g++) begin : g_coord
		if (COORD_WIDTH > FIELD_W) begin : g_wide
			assign v[g] = $signed({1'b0, fld[g]});
		end else begin : g_narrow
			assign v[g] = $signed(fld[g][COORD_WIDTH-1:0]);
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// s1: edges and vertex sum
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [SW-1:0] sum_s1 [3];

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i]  <= EW'(v[3+i]) - EW'(v[i]);
				e2_s1[i]  <= EW'(v[6+i]) - EW'(v[i]);
				sum_s1[i] <= SW'(v[i]) + SW'(v[3+i]) + SW'(v[6+i]);
			end
		end
	end

	// s2: cross product terms, eye and light vectors scaled by three
	logic signed [PW-1:0] prod_s2 [6];
	logic signed [TW-1:0] tv_s2 [3];
	logic signed [TW-1:0] lv_s2 [3];
	logic signed [FIELD_W-1:0] eye [3];
	logic signed [FIELD_W-1:0] lgt [3];

	assign eye[0] = cfg.eye_x;
	assign eye[1] = cfg.eye_y;
	assign eye[2] = cfg.eye_z;
	assign lgt[0] = cfg.light_x;
	assign lgt[1] = cfg.light_y;
	assign lgt[2] = cfg.light_z;

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2[0] <= e1_s1[1] * e2_s1[2];
			prod_s2[1] <= e2_s1[1] * e1_s1[2];
			prod_s2[2] <= e2_s1[0] * e1_s1[2];
			prod_s2[3] <= e1_s1[0] * e2_s1[2];
			prod_s2[4] <= e1_s1[0] * e2_s1[1];
			prod_s2[5] <= e2_s1[0] * e1_s1[1];
			for (int i = 0; i < 3; i++) begin
				tv_s2[i] <= TW'(eye[i]) + (TW'(eye[i]) <<< 1) - TW'(sum_s1[i]);
				lv_s2[i] <= TW'(lgt[i]) + (TW'(lgt[i]) <<< 1) - TW'(sum_s1[i]);
			end
		end
	end

	// s3: normal
	logic signed [NW-1:0] n_s3 [3];
	logic signed [TW-1:0] tv_s3 [3];
	logic signed [TW-1:0] lv_s3 [3];

	always_ff @(posedge clk) begin
		if (advance) begin
			n_s3[0] <= NW'(prod_s2[0]) - NW'(prod_s2[1]);
			n_s3[1] <= NW'(prod_s2[2]) - NW'(prod_s2[3]);
			n_s3[2] <= NW'(prod_s2[4]) - NW'(prod_s2[5]);
			tv_s3 <= tv_s2;
			lv_s3 <= lv_s2;
		end
	end

	// s4: culling products, sign and magnitude split
	logic signed [CPW-1:0] cp_s4 [3];
	logic [NW-1:0] nmag_s4 [3];
	logic [TW-1:0] lmag_s4 [3];
	logic [2:0]    nneg_s4, lneg_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				cp_s4[i]   <= n_s3[i] * tv_s3[i];
				nneg_s4[i] <= n_s3[i][NW-1];
				lneg_s4[i] <= lv_s3[i][TW-1];
				nmag_s4[i] <= n_s3[i][NW-1] ? NW'(-n_s3[i]) : NW'(n_s3[i]);
				lmag_s4[i] <= lv_s3[i][TW-1] ? TW'(-lv_s3[i]) : TW'(lv_s3[i]);
			end
		end
	end

	// s5: cull decision, reduction shift per vector
	logic signed [CSW-1:0] cull_sum;
	logic [NW-1:0]  n_or;
	logic [TW-1:0]  l_or;
	logic [SHN-1:0] n_len, n_sh;
	logic [SHL-1:0] l_len, l_sh;

	always_comb begin
		cull_sum = CSW'(cp_s4[0]) + CSW'(cp_s4[1]) + CSW'(cp_s4[2]);
		n_or = nmag_s4[0] | nmag_s4[1] | nmag_s4[2];
		l_or = lmag_s4[0] | lmag_s4[1] | lmag_s4[2];
		n_len = '0;
		for (int i = 0; i < NW; i++)
			if (n_or[i]) n_len = SHN'(i + 1);
		l_len = '0;
		for (int i = 0; i < TW; i++)
			if (l_or[i]) l_len = SHL'(i + 1);
		n_sh = (n_len > SHN'(RED_BITS)) ? n_len - SHN'(RED_BITS) : '0;
		l_sh = (l_len > SHL'(RED_BITS)) ? l_len - SHL'(RED_BITS) : '0;
	end

	logic           vis_s5;
	logic [SHN-1:0] nsh_s5;
	logic [SHL-1:0] lsh_s5;
	logic [NW-1:0]  nmag_s5 [3];
	logic [TW-1:0]  lmag_s5 [3];
	logic [2:0]     nneg_s5, lneg_s5;

	always_ff @(posedge clk) begin
		if (advance) begin
			vis_s5  <= !cull_sum[CSW-1];
			nsh_s5  <= n_sh;
			lsh_s5  <= l_sh;
			nmag_s5 <= nmag_s4;
			lmag_s5 <= lmag_s4;
			nneg_s5 <= nneg_s4;
			lneg_s5 <= lneg_s4;
		end
	end

	// s6: reduced vectors
	logic [NW-1:0]       n_shf [3];
	logic [TW-1:0]       l_shf [3];
	logic signed [RED_W-1:0] nr_c [3];
	logic signed [RED_W-1:0] lr_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_shf[i] = nmag_s5[i] >> nsh_s5;
			l_shf[i] = lmag_s5[i] >> lsh_s5;
			nr_c[i] = nneg_s5[i] ? -$signed({1'b0, n_shf[i][RED_BITS-1:0]})
			                     :  $signed({1'b0, n_shf[i][RED_BITS-1:0]});
			lr_c[i] = lneg_s5[i] ? -$signed({1'b0, l_shf[i][RED_BITS-1:0]})
			                     :  $signed({1'b0, l_shf[i][RED_BITS-1:0]});
		end
	end

	logic                    vis_s6;
	logic signed [RED_W-1:0] nr_s6 [3];
	logic signed [RED_W-1:0] lr_s6 [3];

	always_ff @(posedge clk) begin
		if (advance) begin
			vis_s6 <= vis_s5;
			nr_s6  <= nr_c;
			lr_s6  <= lr_c;
		end
	end

	// s7: dot and square terms
	logic signed [DOT_W-1:0] nsq_c [3];
	logic signed [DOT_W-1:0] lsq_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nsq_c[i] = nr_s6[i] * nr_s6[i];
			lsq_c[i] = lr_s6[i] * lr_s6[i];
		end
	end

	logic                    vis_s7;
	logic signed [DOT_W-1:0] dp_s7 [3];
	logic [SQW-1:0]          nsq_s7 [3];
	logic [SQW-1:0]          lsq_s7 [3];

	always_ff @(posedge clk) begin
		if (advance) begin
			vis_s7 <= vis_s6;
			for (int i = 0; i < 3; i++) begin
				dp_s7[i]  <= nr_s6[i] * lr_s6[i];
				nsq_s7[i] <= nsq_c[i][SQW-1:0];
				lsq_s7[i] <= lsq_c[i][SQW-1:0];
			end
		end
	end

	// s8: sums
	logic                  vis_s8;
	logic signed [DOT_W:0] d_s8;
	logic [DOT_W-1:0]      nn_s8, ll_s8;

	always_ff @(posedge clk) begin
		if (advance) begin
			vis_s8 <= vis_s7;
			d_s8   <= (DOT_W+1)'(dp_s7[0]) + (DOT_W+1)'(dp_s7[1]) + (DOT_W+1)'(dp_s7[2]);
			nn_s8  <= DOT_W'(nsq_s7[0]) + DOT_W'(nsq_s7[1]) + DOT_W'(nsq_s7[2]);
			ll_s8  <= DOT_W'(lsq_s7[0]) + DOT_W'(lsq_s7[1]) + DOT_W'(lsq_s7[2]);
		end
	end

	// s9: radicand for the norm product
	rad_item_t item_s9;

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s9.visible <= vis_s8;
			item_s9.pos     <= !d_s8[DOT_W] && (d_s8 != '0);
			item_s9.dmag    <= d_s8[DOT_W-1:0];
			item_s9.rad     <= nn_s8 * ll_s8;
		end
	end

	assign out_vld  = vld_s9;
	assign out_item = item_s9;

endmodule
`default_nettype wire

FILE: src/fsct_sqrt.sv
`default_nettype none
module fsct_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 in_vld,
	input  fsct_pkg::rad_item_t  in_item,
	output logic                 out_vld,
	output fsct_pkg::root_item_t out_item
);
	import fsct_pkg::*;

	logic [RAD_W-1:0] rem_s [SQ_STEPS];
	logic [RAD_W-1:0] res_s [SQ_STEPS];
	logic [DOT_W-1:0] dmag_s [SQ_STEPS];
	logic             vld_s [SQ_STEPS];
	logic             vis_s [SQ_STEPS];
	logic             pos_s [SQ_STEPS];

	// one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (SQ_STEPS - 1 - k));

		logic [RAD_W-1:0] rem_in, res_in, rem_nx, res_nx;
		logic [RAD_W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_in = in_item.rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end

		always_comb begin
			trial = {1'b0, res_in} + BIT;
			if ({1'b0, rem_in} >= trial) begin
				rem_nx = rem_in - trial[RAD_W-1:0];
				res_nx = (res_in >> 1) + BIT[RAD_W-1:0];
			end else begin
				rem_nx = rem_in;
				res_nx = res_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (advance) begin
				vld_s[k] <= (k == 0) ? in_vld : vld_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k]  <= rem_nx;
				res_s[k]  <= res_nx;
				dmag_s[k] <= (k == 0) ? in_item.dmag : dmag_s[(k == 0) ? 0 : k-1];
				vis_s[k]  <= (k == 0) ? in_item.visible : vis_s[(k == 0) ? 0 : k-1];
				pos_s[k]  <= (k == 0) ? in_item.pos : pos_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign out_vld          = vld_s[SQ_STEPS-1];
	assign out_item.visible = vis_s[SQ_STEPS-1];
	assign out_item.pos     = pos_s[SQ_STEPS-1];
	assign out_item.dmag    = dmag_s[SQ_STEPS-1];
	assign out_item.root    = res_s[SQ_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: src/fsct_div.sv
`default_nettype none
module fsct_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 in_vld,
	input  fsct_pkg::root_item_t in_item,
	input  fsct_pkg::cfg_t       cfg,
	output logic                 out_vld,
	output fsct_pkg::out_item_t  out_item
);
	import fsct_pkg::*;

	logic [NUM_W-1:0]  rem_s  [QUO_W+1];
	logic [QUO_W-1:0]  quo_s  [QUO_W+1];
	logic [ROOT_W-1:0] root_s [QUO_W+1];
	logic              vld_s  [QUO_W+1];
	logic              vis_s  [QUO_W+1];
	logic              pos_s  [QUO_W+1];

	// numerator: gain times dot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0]  <= in_item.pos ? cfg.diffuse_gain * in_item.dmag : '0;
			quo_s[0]  <= '0;
			root_s[0] <= in_item.root;
			vis_s[0]  <= in_item.visible;
			pos_s[0]  <= in_item.pos;
		end
	end

	// restoring division, quotient MSB first
	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		localparam int QB = QUO_W - 1 - j;

		logic [NUM_W-1:0] den;
		logic             ge;

		assign den = NUM_W'(root_s[j]) << QB;
		assign ge  = rem_s[j] >= den;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (advance) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[j+1]  <= ge ? rem_s[j] - den : rem_s[j];
				quo_s[j+1]  <= quo_s[j] | (QUO_W'(ge) << QB);
				root_s[j+1] <= root_s[j];
				vis_s[j+1]  <= vis_s[j];
				pos_s[j+1]  <= pos_s[j];
			end
		end
	end

	logic [QUO_W-1:0] diffuse;
	logic [QUO_W:0]   total;
	logic [7:0]       inten;

	always_comb begin
		diffuse = pos_s[QUO_W] ? quo_s[QUO_W] : '0;
		total   = {1'b0, diffuse} + {1'b0, cfg.ambient_term};
		inten   = total[QUO_W] ? 8'hFF : total[7:0];
		out_item.visible        = vis_s[QUO_W];
		out_item.intensity      = vis_s[QUO_W] ? inten : 8'd0;
		out_item.half_intensity = vis_s[QUO_W] ? inten[7:1] : 7'd0;
	end

	assign out_vld = vld_s[QUO_W];

endmodule
`default_nettype wire

FILE: src/flat_shade_cull_triangle.sv
// Flat Lambert shading with back-face culling, one triangle per beat.
// vtx channel: vtx_valid / vtx_stall with vtx_beat holding three vertices in
//   signed Q4.12. A beat is taken when vtx_valid is high and vtx_stall low.
// shade channel: shade_valid / shade_stall with shade_beat holding visible,
//   intensity and half_intensity; exactly one result per triangle, in order.
// cfg channel: cfg_valid / cfg_ready (always ready), cfg_index selects eye
//   x/y/z, light x/y/z, ambient term, diffuse gain; other indexes are ignored.
//   Write it only while no triangle is in flight.
// Pipeline from an accepted beat to its result on shade_beat:
//   9 geometry stages, 30 square-root stages (one root bit each), one gain
//   multiply, 8 divide stages (one quotient bit each), one output register.
// Throughput: one triangle per cycle while vtx_stall is low.
// Reset clears all valid bits and loads the register defaults; the block
//   accepts a beat as soon as reset is released.
// When the receiver stalls, a skid register catches the one result in
//   flight; vtx_stall then rises, the whole pipeline holds, and it restarts
//   the cycle after the skid register drains. Nothing is lost or repeated.
`default_nettype none
module flat_shade_cull_triangle #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_valid,
	output logic                vtx_stall,
	input  fsct_pkg::in_item_t  vtx_beat,
	output logic                shade_valid,
	input  logic                shade_stall,
	output fsct_pkg::out_item_t shade_beat,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import fsct_pkg::*;

	cfg_t       regs;
	logic       advance;
	logic       geom_vld, sqrt_vld, div_vld;
	rad_item_t  geom_item;
	root_item_t sqrt_item;
	out_item_t  div_item;

	logic      skid_full_q, out_vld_q;
	out_item_t skid_q, out_q;
	logic      take;

	assign advance   = !skid_full_q;
	assign vtx_stall = skid_full_q;

	fsct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	fsct_geom #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_vld   (vtx_valid),
		.in_item  (vtx_beat),
		.cfg      (regs),
		.out_vld  (geom_vld),
		.out_item (geom_item)
	);

	fsct_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_vld   (geom_vld),
		.in_item  (geom_item),
		.out_vld  (sqrt_vld),
		.out_item (sqrt_item)
	);

	fsct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_vld   (sqrt_vld),
		.in_item  (sqrt_item),
		.cfg      (regs),
		.out_vld  (div_vld),
		.out_item (div_item)
	);

	assign take = out_vld_q && !shade_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) begin
				skid_full_q <= 1'b0;
			end
		end else if (div_vld) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (div_vld) begin
			if (!out_vld_q || take) begin
				out_q <= div_item;
			end else begin
				skid_q <= div_item;
			end
		end
	end

	assign shade_valid = out_vld_q;
	assign shade_beat  = out_q;

endmodule
`default_nettype wire

FILE: src/fsct_checker.sv
`default_nettype none
module fsct_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                vtx_stall,
	input logic                shade_valid,
	input logic                shade_stall,
	input fsct_pkg::out_item_t shade_beat
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		shade_valid && shade_stall |=> shade_valid && $stable(shade_beat))
		else $error("stalled result changed");

	a_culled_dark: assert property (@(posedge clk) disable iff (!arst_n)
		shade_valid && !shade_beat.visible |->
			shade_beat.intensity == 8'd0 && shade_beat.half_intensity == 7'd0)
		else $error("culled face carries intensity");

	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		shade_valid |-> shade_beat.half_intensity == shade_beat.intensity[7:1])
		else $error("green channel is not half of intensity");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_stall |-> $past(shade_valid && shade_stall))
		else $error("input stalled without a blocked result");

endmodule

bind flat_shade_cull_triangle fsct_checker u_fsct_checker (.*);
`default_nettype wire

FILE: tb/sv/flat_shade_cull_triangle_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module flat_shade_cull_triangle_tb;
	import fsct_pkg::*;

	localparam int LATENCY = 48;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        vtx_valid = 1'b0;
	logic        vtx_stall;
	in_item_t    vtx_beat = '0;
	logic        shade_valid;
	logic        shade_stall = 1'b0;
	out_item_t   shade_beat;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	flat_shade_cull_triangle uut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx_beat(vtx_beat),
		.shade_valid(shade_valid), .shade_stall(shade_stall), .shade_beat(shade_beat),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shading settings mirrored by the predictor
	longint eye[3], light[3];
	longint ambient, gain;

	in_item_t  tri_queue[$];
	out_item_t shade_expected[$];
	int  send_idle_pct = 0, recv_idle_pct = 0;
	bit  failed = 0;
	bit  cfg_pending = 0;
	logic [3:0]  cfg_idx_next;
	logic [15:0] cfg_val_next;

	function automatic void add_tri(in_item_t t);
		tri_queue.insert(tri_queue.size(), t);
	endfunction

	function automatic void reset_settings();
		eye[0] = 0; eye[1] = 0; eye[2] = 12288;
		light[0] = 0; light[1] = 0; light[2] = 12288;
		ambient = 50; gain = 160;
	endfunction

	function automatic void apply_setting(logic [3:0] idx, logic [15:0] val);
		case (idx)
			REG_EYE_X:   eye[0] = longint'($signed(val));
			REG_EYE_Y:   eye[1] = longint'($signed(val));
			REG_EYE_Z:   eye[2] = longint'($signed(val));
			REG_LIGHT_X: light[0] = longint'($signed(val));
			REG_LIGHT_Y: light[1] = longint'($signed(val));
			REG_LIGHT_Z: light[2] = longint'($signed(val));
			REG_AMBIENT: ambient = val[7:0];
			REG_DIFFUSE: gain = val[7:0];
			default: ;
		endcase
	endfunction

	function automatic void shrink_vec(input longint a[3], output longint r[3]);
		longint mag[3];
		longint mx;
		int sh;
		mx = 0;
		sh = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = a[i] < 0 ? -a[i] : a[i];
			if (mag[i] > mx) mx = mag[i];
		end
		while ((mx >> sh) >= 16384) sh++;
		for (int i = 0; i < 3; i++) r[i] = a[i] < 0 ? -(mag[i] >> sh) : (mag[i] >> sh);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic out_item_t shade_triangle(in_item_t t);
		longint v[9], e1[3], e2[3], n[3], sum[3], lv[3], nr[3], lr[3];
		longint facing, d;
		longint unsigned nn, ll, s, inten;
		out_item_t r;
		v = '{t.vert0_x, t.vert0_y, t.vert0_z, t.vert1_x, t.vert1_y, t.vert1_z,
			t.vert2_x, t.vert2_y, t.vert2_z};
		for (int i = 0; i < 3; i++) begin
			e1[i] = v[3+i] - v[i];
			e2[i] = v[6+i] - v[i];
			sum[i] = v[i] + v[3+i] + v[6+i];
		end
		n[0] = e1[1] * e2[2] - e2[1] * e1[2];
		n[1] = e2[0] * e1[2] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e2[0] * e1[1];
		facing = 0;
		for (int i = 0; i < 3; i++) begin
			facing += n[i] * (3 * eye[i] - sum[i]);
			lv[i] = 3 * light[i] - sum[i];
		end
		r = '0;
		if (facing < 0) return r;
		shrink_vec(n, nr);
		shrink_vec(lv, lr);
		d = nr[0] * lr[0] + nr[1] * lr[1] + nr[2] * lr[2];
		inten = 0;
		if (d > 0) begin
			nn = nr[0] * nr[0] + nr[1] * nr[1] + nr[2] * nr[2];
			ll = lr[0] * lr[0] + lr[1] * lr[1] + lr[2] * lr[2];
			s = int_sqrt(nn * ll);
			if (s != 0) inten = (longint'(gain) * d) / s;
		end
		inten += ambient;
		if (inten > 255) inten = 255;
		r.visible = 1'b1;
		r.intensity = inten[7:0];
		r.half_intensity = inten[7:1];
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!vtx_valid || !vtx_stall) begin
				if (vtx_valid)
					shade_expected.insert(shade_expected.size(), shade_triangle(vtx_beat));
				if (tri_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					vtx_beat <= tri_queue.pop_front();
					vtx_valid <= 1'b1;
				end else begin
					vtx_valid <= 1'b0;
				end
			end
			shade_stall <= ($urandom_range(99) < recv_idle_pct);
			if (cfg_valid && cfg_ready) begin
				apply_setting(cfg_index, cfg_data);
				cfg_valid <= 1'b0;
			end else if (cfg_pending && !cfg_valid) begin
				cfg_index <= cfg_idx_next;
				cfg_data <= cfg_val_next;
				cfg_valid <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && shade_valid && !shade_stall) begin
			if (shade_expected.size() == 0) begin
				$error("unexpected result %p", shade_beat);
				failed = 1;
			end else begin
				want = shade_expected.pop_front();
				if (shade_beat.visible !== want.visible) begin
					$error("visible exp %0d got %0d", want.visible, shade_beat.visible);
					failed = 1;
				end
				if (shade_beat.intensity !== want.intensity) begin
					$error("intensity exp %0d got %0d", want.intensity, shade_beat.intensity);
					failed = 1;
				end
				if (shade_beat.half_intensity !== want.half_intensity) begin
					$error("half_intensity exp %0d got %0d", want.half_intensity,
						shade_beat.half_intensity);
					failed = 1;
				end
			end
		end
	end

	task automatic drain();
		while (tri_queue.size() > 0 || vtx_valid || shade_expected.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] val);
		cfg_idx_next = idx;
		cfg_val_next = val;
		cfg_pending = 1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_pending = 0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(4095) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_tri();
		in_item_t t;
		t = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
		if ($urandom_range(3) != 0) begin
			t.vert0_x = rand_coord(); t.vert0_y = rand_coord(); t.vert0_z = rand_coord();
			t.vert1_x = rand_coord(); t.vert1_y = rand_coord(); t.vert1_z = rand_coord();
			t.vert2_x = rand_coord(); t.vert2_y = rand_coord(); t.vert2_z = rand_coord();
		end
		if ($urandom_range(15) == 0) t.vert2_x = t.vert1_x;
		if ($urandom_range(15) == 0) begin
			t.vert2_y = t.vert1_y;
			t.vert2_z = t.vert1_z;
			t.vert2_x = t.vert1_x;
		end
		return t;
	endfunction

	function automatic in_item_t mk_tri(int a, int b, int c, int d, int e, int f,
		int g, int h, int k);
		in_item_t t;
		t = {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h), 16'(k)};
		return t;
	endfunction

	initial begin
		reset_settings();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// front face, back face, degenerate, extremes
		add_tri(mk_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
		add_tri(mk_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
		add_tri(mk_tri(100, 200, 300, 100, 200, 300, 100, 200, 300));
		add_tri(mk_tri(0, 0, 0, 4096, 4096, 0, 8192, 8192, 0));
		add_tri(mk_tri(-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768));
		add_tri(mk_tri(32767, 32767, 32767, -32768, 32767, 32767,
			32767, -32768, 32767));
		add_tri(mk_tri(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0));
		add_tri(mk_tri(0, 0, 12288, 4096, 0, 12288, 0, 4096, 12288));
		add_tri(mk_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		for (int i = 0; i < 10; i++) add_tri(rand_tri());
		drain();

		// light at centroid, full gain, ambient clamp
		write_reg(REG_LIGHT_X, 16'd4096);
		write_reg(REG_LIGHT_Y, 16'd4096);
		write_reg(REG_LIGHT_Z, 16'd0);
		write_reg(REG_AMBIENT, 16'd255);
		write_reg(REG_DIFFUSE, 16'd255);
		add_tri(mk_tri(0, 0, 0, 12288, 0, 0, 0, 12288, 0));
		add_tri(mk_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
		drain();
		write_reg(REG_AMBIENT, 16'd0);
		add_tri(mk_tri(0, 0, 0, 12288, 0, 0, 0, 12288, 0));
		add_tri(mk_tri(0, 0, -4096, 4096, 0, -4096, 0, 4096, -4096));
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			send_idle_pct = (phase < 3) ? 19 : (phase < 6) ? 58 : 0;
			recv_idle_pct = (phase < 3) ? 58 : (phase < 6) ? 19 : 0;
			case (phase)
				0: begin
					write_reg(REG_EYE_X, 16'h8000); write_reg(REG_EYE_Y, 16'h7fff);
					write_reg(REG_EYE_Z, 16'h8000);
				end
				1: begin
					write_reg(REG_EYE_X, 16'h7fff); write_reg(REG_EYE_Y, 16'h8000);
					write_reg(REG_EYE_Z, 16'h7fff); write_reg(REG_LIGHT_X, 16'h8000);
					write_reg(REG_LIGHT_Y, 16'h7fff); write_reg(REG_LIGHT_Z, 16'h8000);
				end
				2: begin
					write_reg(REG_LIGHT_X, 16'h7fff); write_reg(REG_LIGHT_Y, 16'h8000);
					write_reg(REG_LIGHT_Z, 16'h7fff); write_reg(REG_DIFFUSE, 16'd0);
					write_reg(REG_AMBIENT, 16'd128);
				end
				3: write_reg(4'd9, 16'($urandom));
				default: begin
					for (int r = 0; r < 8; r++) write_reg(r[3:0], 16'($urandom));
				end
			endcase
			for (int i = 0; i < 205; i++) add_tri(rand_tri());
			// let about half the phase go out first
			while (tri_queue.size() > 100) @(posedge clk);
			if (phase == 1) begin
				send_idle_pct = 100;
				while (shade_expected.size() > 0 || vtx_valid) @(posedge clk);
				send_idle_pct = 19;
			end
			drain();
		end

		if (!failed) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
